/* rtl/core/pli_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants for the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

   localparam int MAX_POINTS = 16;
   localparam int PT_IDX_W   = $clog2(MAX_POINTS);
   localparam int CNT_W      = PT_IDX_W + 1;
   localparam int DATA_W     = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = CNT_W;
   localparam int DIV_STEPS  = DATA_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_EVAL  = 1'b1
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINEAR_MODE   = 3'd0,
      CSR_ALLOW_LEFT    = 3'd1,
      CSR_ALLOW_RIGHT   = 3'd2,
      CSR_POINTS_IN_USE = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
   } point_type;

   typedef struct packed {
      logic                en;
      logic [PT_IDX_W-1:0] addr;
      point_type           data;
   } tbl_wr_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] mag;
      logic [DATA_W-1:0] dx;
      logic [DATA_W-1:0] den;
   } md_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quotient;
   } md_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_SEARCH,
      ST_DECIDE,
      ST_CALC
   } pli_state_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV
   } md_state_type;

endpackage

/* rtl/core/pli_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_table
// Breakpoint memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module pli_table (
   input  logic                          clock,
   input  pli_pkg::tbl_wr_type           wr,
   input  logic [pli_pkg::PT_IDX_W-1:0]  rd_addr,
   output pli_pkg::point_type            rd_data
);

   pli_pkg::point_type mem [pli_pkg::MAX_POINTS];
   pli_pkg::point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/pli_muldiv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pli_muldiv
// Computes (mag * dx) / den: one registered 32x32 multiply, then a
// restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pli_muldiv (
   input  logic                clock,
   input  logic                reset,
   input  pli_pkg::md_req_type req,
   output pli_pkg::md_rsp_type rsp
);

   pli_pkg::md_state_type state_ff, state_in;

   logic [pli_pkg::DATA_W-1:0]    a_ff, b_ff, den_ff;
   logic [pli_pkg::DATA_W-1:0]    rem_ff, low_ff;
   logic [pli_pkg::DIV_CNT_W-1:0] step_ff;
   logic                          done_ff;

   logic                          capture;
   logic                          last_step;
   logic [2*pli_pkg::DATA_W-1:0]  product;
   logic [pli_pkg::DATA_W:0]      trial;
   logic [pli_pkg::DATA_W:0]      trial_sub;
   logic                          ge;
   logic [pli_pkg::DATA_W-1:0]    rem_in, low_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pli_pkg::MD_IDLE: begin
            if (req.start) begin
               state_in = pli_pkg::MD_MUL;
            end
         end
         pli_pkg::MD_MUL: begin
            state_in = pli_pkg::MD_DIV;
         end
         pli_pkg::MD_DIV: begin
            if (last_step) begin
               state_in = pli_pkg::MD_IDLE;
            end
         end
         default: begin
            state_in = pli_pkg::MD_IDLE;
         end
      endcase
   end

   // Control outputs.
   always_comb begin
      capture   = (state_ff == pli_pkg::MD_IDLE) && req.start;
      last_step = (state_ff == pli_pkg::MD_DIV) &&
                  (step_ff == pli_pkg::DIV_CNT_W'(pli_pkg::DIV_STEPS - 1));
   end

   // The quotient is known to fit in 32 bits, so the upper half of the
   // product is already below the divisor and only 32 steps are needed.
   always_comb begin
      product   = a_ff * b_ff;
      trial     = {rem_ff, low_ff[pli_pkg::DATA_W-1]};
      trial_sub = trial - {1'b0, den_ff};
      ge        = (trial >= {1'b0, den_ff});
      rem_in    = ge ? trial_sub[pli_pkg::DATA_W-1:0] : trial[pli_pkg::DATA_W-1:0];
      low_in    = {low_ff[pli_pkg::DATA_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pli_pkg::MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= last_step;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         a_ff   <= req.mag;
         b_ff   <= req.dx;
         den_ff <= req.den;
      end
      case (state_ff)
         pli_pkg::MD_MUL: begin
            rem_ff  <= product[2*pli_pkg::DATA_W-1:pli_pkg::DATA_W];
            low_ff  <= product[pli_pkg::DATA_W-1:0];
            step_ff <= '0;
         end
         pli_pkg::MD_DIV: begin
            rem_ff  <= rem_in;
            low_ff  <= low_in;
            step_ff <= step_ff + pli_pkg::DIV_CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = low_ff;

endmodule

/* rtl/core/piecewise_linear_interpolator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Breakpoint table with a sequential search and a multiply/divide
// unit for linear interpolation between neighboring breakpoints.
// ----------------------------------------------------------------------------
// A write item is stored at its accept edge; busy stays low.
// An evaluate item scans all n active breakpoints, one memory read a cycle.
// Its result strobe follows the fill, search and decide states without
// interpolation, and also one multiply and 32 divide steps with it; busy
// drops in the strobe cycle, so the next item can be accepted in that cycle.
// Synchronous reset clears the sequencer, the control registers and the strobe; the table is not cleared.
module piecewise_linear_interpolator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_opcode,
   input  logic [pli_pkg::PT_IDX_W-1:0]          req_point_index,
   input  logic signed [pli_pkg::DATA_W-1:0]     req_x_value,
   input  logic signed [pli_pkg::DATA_W-1:0]     req_y_value,
   output logic                                  rsp_strobe,
   output logic signed [pli_pkg::DATA_W-1:0]     rsp_y_result,
   output logic                                  rsp_inside_domain,
   input  logic                                  csr_write_enable,
   input  logic [pli_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pli_pkg::CSR_DATA_W-1:0]        csr_write_data
);

   localparam int W = pli_pkg::DATA_W;

   pli_pkg::pli_state_type state_ff, state_in;

   logic                          linear_mode_ff;
   logic                          allow_left_ff;
   logic                          allow_right_ff;
   logic [pli_pkg::CNT_W-1:0]     points_in_use_ff;

   logic signed [W-1:0]           xq_ff;
   logic [pli_pkg::PT_IDX_W-1:0]  addr_ff;
   logic [pli_pkg::PT_IDX_W-1:0]  cnt_ff;
   logic                          found_ff;
   logic                          zero_ff;
   logic                          neg_ff;
   logic                          dom_ff;
   pli_pkg::point_type            prev_ff, left_ff, right_ff, last_ff;

   logic                          rsp_strobe_ff;
   logic signed [W-1:0]           rsp_y_ff;
   logic                          rsp_dom_ff;

   logic                          accept;
   logic                          load_query;
   logic                          search_en;
   logic                          decide_en;
   logic                          calc_done;
   logic                          interp;
   logic                          scan_last;
   logic                          hit;
   logic                          dom;
   logic [pli_pkg::PT_IDX_W-1:0]  last_idx;
   logic signed [W-1:0]           y_direct;
   logic signed [W:0]             dy;
   logic [W:0]                    dy_mag;
   logic [W:0]                    dx_full;
   logic [W:0]                    den_full;
   logic signed [W+1:0]           sum;
   logic signed [W-1:0]           y_interp;

   pli_pkg::tbl_wr_type           tbl_wr;
   pli_pkg::point_type            rd_data;
   pli_pkg::md_req_type           md_req;
   pli_pkg::md_rsp_type           md_rsp;

   assign accept = start && !busy;

   // A count of zero acts as one; counts above the table size saturate.
   always_comb begin
      if (points_in_use_ff == '0) begin
         last_idx = '0;
      end else if (points_in_use_ff > pli_pkg::CNT_W'(pli_pkg::MAX_POINTS)) begin
         last_idx = pli_pkg::PT_IDX_W'(pli_pkg::MAX_POINTS - 1);
      end else begin
         last_idx = pli_pkg::PT_IDX_W'(points_in_use_ff - pli_pkg::CNT_W'(1));
      end
   end

   always_comb begin
      scan_last = (cnt_ff == last_idx);
      hit       = !found_ff && (rd_data.x > xq_ff);
      interp    = found_ff && !zero_ff && linear_mode_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pli_pkg::ST_IDLE: begin
            if (load_query) begin
               state_in = pli_pkg::ST_FILL;
            end
         end
         pli_pkg::ST_FILL: begin
            state_in = pli_pkg::ST_SEARCH;
         end
         pli_pkg::ST_SEARCH: begin
            if (scan_last) begin
               state_in = pli_pkg::ST_DECIDE;
            end
         end
         pli_pkg::ST_DECIDE: begin
            state_in = interp ? pli_pkg::ST_CALC : pli_pkg::ST_IDLE;
         end
         pli_pkg::ST_CALC: begin
            if (md_rsp.done) begin
               state_in = pli_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pli_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      busy       = (state_ff != pli_pkg::ST_IDLE);
      load_query = accept && (pli_pkg::opcode_type'(req_opcode) == pli_pkg::OP_EVAL);
      search_en  = (state_ff == pli_pkg::ST_SEARCH);
      decide_en  = (state_ff == pli_pkg::ST_DECIDE);
      calc_done  = (state_ff == pli_pkg::ST_CALC) && md_rsp.done;
   end

   always_comb begin
      tbl_wr.en        = accept && (pli_pkg::opcode_type'(req_opcode) == pli_pkg::OP_WRITE);
      tbl_wr.addr      = req_point_index;
      tbl_wr.data.x    = req_x_value;
      tbl_wr.data.y    = req_y_value;
   end

   pli_table u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // Found at slot zero means the query lies below the first breakpoint.
   always_comb begin
      dom = !((!allow_left_ff && found_ff && zero_ff) ||
              (!allow_right_ff && (xq_ff > last_ff.x)));
      if (!found_ff) begin
         y_direct = last_ff.y;
      end else if (zero_ff) begin
         y_direct = right_ff.y;
      end else begin
         y_direct = left_ff.y;
      end
   end

   // Operands for the multiply/divide unit; all differences are taken at 33 bits.
   always_comb begin
      dy       = {right_ff.y[W-1], right_ff.y} - {left_ff.y[W-1], left_ff.y};
      dy_mag   = dy[W] ? (~dy + (W+1)'(1)) : dy;
      dx_full  = {xq_ff[W-1], xq_ff} - {left_ff.x[W-1], left_ff.x};
      den_full = {right_ff.x[W-1], right_ff.x} - {left_ff.x[W-1], left_ff.x};
      md_req.start = decide_en && interp;
      md_req.mag   = dy_mag[W-1:0];
      md_req.dx    = dx_full[W-1:0];
      md_req.den   = den_full[W-1:0];
   end

   pli_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .req   (md_req),
      .rsp   (md_rsp)
   );

   always_comb begin
      if (neg_ff) begin
         sum = {{2{left_ff.y[W-1]}}, left_ff.y} - {2'b00, md_rsp.quotient};
      end else begin
         sum = {{2{left_ff.y[W-1]}}, left_ff.y} + {2'b00, md_rsp.quotient};
      end
      if (sum[W+1:W-1] == 3'b000 || sum[W+1:W-1] == 3'b111) begin
         y_interp = sum[W-1:0];
      end else if (sum[W+1]) begin
         y_interp = {1'b1, {(W-1){1'b0}}};
      end else begin
         y_interp = {1'b0, {(W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= pli_pkg::ST_IDLE;
         linear_mode_ff   <= 1'b1;
         allow_left_ff    <= 1'b0;
         allow_right_ff   <= 1'b0;
         points_in_use_ff <= pli_pkg::CNT_W'(1);
         rsp_strobe_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= (decide_en && !interp) || calc_done;
         if (csr_write_enable) begin
            case (pli_pkg::csr_index_type'(csr_index))
               pli_pkg::CSR_LINEAR_MODE:   linear_mode_ff   <= csr_write_data[0];
               pli_pkg::CSR_ALLOW_LEFT:    allow_left_ff    <= csr_write_data[0];
               pli_pkg::CSR_ALLOW_RIGHT:   allow_right_ff   <= csr_write_data[0];
               pli_pkg::CSR_POINTS_IN_USE: points_in_use_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
      end
   end

   // Search datapath: the memory returns entry cnt_ff in each search cycle.
   always_ff @(posedge clock) begin
      if (load_query) begin
         xq_ff    <= req_x_value;
         addr_ff  <= '0;
         cnt_ff   <= '0;
         found_ff <= 1'b0;
         zero_ff  <= 1'b0;
      end else if (state_ff == pli_pkg::ST_FILL) begin
         addr_ff <= addr_ff + pli_pkg::PT_IDX_W'(1);
      end else if (search_en) begin
         addr_ff <= addr_ff + pli_pkg::PT_IDX_W'(1);
         cnt_ff  <= cnt_ff + pli_pkg::PT_IDX_W'(1);
         prev_ff <= rd_data;
         if (hit) begin
            found_ff <= 1'b1;
            zero_ff  <= (cnt_ff == '0);
            left_ff  <= prev_ff;
            right_ff <= rd_data;
         end
         if (scan_last) begin
            last_ff <= rd_data;
         end
      end
      if (decide_en) begin
         dom_ff <= dom;
         neg_ff <= dy[W];
      end
      if (decide_en && !interp) begin
         rsp_y_ff   <= y_direct;
         rsp_dom_ff <= dom;
      end else if (calc_done) begin
         rsp_y_ff   <= y_interp;
         rsp_dom_ff <= dom_ff;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_y_result      = rsp_y_ff;
   assign rsp_inside_domain = rsp_dom_ff;

endmodule
